@@ design/pdm_pkg.sv @@
// Shared types and constants for the pulse-per-second drift monitor.
// Used by pps_drift_monitor_fifo_unit; depends on nothing.
package pdm_pkg;

    localparam int FIFO_DEPTH = 64;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    localparam int SEC_W   = 32;
    localparam int NSEC_W  = 30;
    localparam int SHIFT_W = 31;
    localparam int COUNT_W = 32;

    localparam logic signed [32:0] NS_PER_SEC = 33'sd1000000000;
    localparam logic signed [COUNT_W-1:0] SYNC_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [1:0] {
        ACT_PULSE = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_RSVD  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_STORED        = 3'd0,
        ST_IN_SYNC       = 3'd1,
        ST_LOSS_REPORTED = 3'd2,
        ST_FULL_DROP     = 3'd3,
        ST_POPPED        = 3'd4,
        ST_EMPTY         = 3'd5,
        ST_CLEARED       = 3'd6,
        ST_BAD_ACTION    = 3'd7
    } status_t;

    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift;
        logic signed [COUNT_W-1:0] count;
        logic signed [SEC_W-1:0]   sec;
        logic [NSEC_W-1:0]         nsec;
    } fifo_entry_t;

endpackage

@@ design/pps_drift_monitor_fifo_unit.sv @@
// Pulse-per-second drift monitor: expected-time tracking plus event FIFO.
// Depends on pdm_pkg (types, codes, FIFO depth).
//
// An accepted word passes through stage 1 (event-memory read, status) and
// stage 2 (output register). Throughput: one word per cycle unless both
// stages are full and the result is stalled; the event memory has one write
// and one read port, and a word does either a push or a pop, never both.
// Reset: pointers, fill count, sync count and expected time go to zero and
// the pipeline empties at once. The event memory is not cleared; every entry
// is written before it can be popped.
module pps_drift_monitor_fifo_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               item_valid,
    output logic                               item_stall,
    input  logic [1:0]                         action,
    input  logic signed [pdm_pkg::SEC_W-1:0]   stamp_sec,
    input  logic [pdm_pkg::NSEC_W-1:0]         stamp_nsec,
    // result channel
    output logic                               result_valid,
    input  logic                               result_stall,
    output logic [2:0]                         status,
    output logic signed [pdm_pkg::SHIFT_W-1:0] shift_out,
    output logic signed [pdm_pkg::COUNT_W-1:0] sync_count_out,
    output logic signed [pdm_pkg::SEC_W-1:0]   event_sec,
    output logic [pdm_pkg::NSEC_W-1:0]         event_nsec,
    output logic [pdm_pkg::FILL_W-1:0]         fill_level
);
    import pdm_pkg::*;

    // ------------------------------------------------------------------
    // Architectural state (all in flops except the event memory)
    // ------------------------------------------------------------------
    logic signed [SEC_W-1:0]   exp_sec_reg,    exp_sec_next;
    logic signed [SHIFT_W-1:0] exp_nsec_reg,   exp_nsec_next;  // -1 after clear
    logic signed [COUNT_W-1:0] sync_count_reg, sync_count_next;
    logic [PTR_W-1:0]          rd_ptr_reg,     rd_ptr_next;
    logic [PTR_W-1:0]          wr_ptr_reg,     wr_ptr_next;
    logic [FILL_W-1:0]         fill_count_reg, fill_count_next;

    fifo_entry_t event_mem [FIFO_DEPTH];
    fifo_entry_t rd_data_reg;
    fifo_entry_t wr_data;
    logic        mem_we;
    logic        mem_re;

    // Stage 1: memory read in flight plus the word's status.
    logic              s1_valid_reg;
    status_t           s1_status_reg, s1_status_next;
    logic [FILL_W-1:0] s1_fill_reg;
    logic              s1_pop_reg;

    // Stage 2: output register.
    logic                      out_valid_reg;
    status_t                   out_status_reg;
    logic signed [SHIFT_W-1:0] out_shift_reg;
    logic signed [COUNT_W-1:0] out_count_reg;
    logic signed [SEC_W-1:0]   out_sec_reg;
    logic [NSEC_W-1:0]         out_nsec_reg;
    logic [FILL_W-1:0]         out_fill_reg;

    logic item_accept;
    logic s2_load;

    // ------------------------------------------------------------------
    // Handshake. Stage 1 drains into stage 2 whenever stage 2 is empty or
    // being taken, so a waiting result does not block the next word.
    // ------------------------------------------------------------------
    assign s2_load     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall  = s1_valid_reg && out_valid_reg && result_stall;
    assign item_accept = item_valid && !item_stall;

    // ------------------------------------------------------------------
    // Drift arithmetic: expected = stored + 1 s, compared with the stamp.
    // ------------------------------------------------------------------
    logic signed [SEC_W-1:0] xs;
    logic signed [32:0]      sec_diff;
    logic signed [31:0]      nsec_diff;
    logic signed [32:0]      shift_full;
    logic signed [32:0]      sec_adj;
    logic                    sec_pos;
    logic                    sec_neg;
    logic                    nd_neg;
    logic                    nd_pos;
    logic                    whole_sec_ok;   // whole-second difference is zero
    logic                    shift_zero;
    logic                    loss;
    logic                    push_req;
    logic                    fifo_full;

    always_comb
    begin
        xs        = exp_sec_reg + 32'sd1;
        sec_diff  = {xs[SEC_W-1], xs} - {stamp_sec[SEC_W-1], stamp_sec};
        nsec_diff = {exp_nsec_reg[SHIFT_W-1], exp_nsec_reg} - {2'b00, stamp_nsec};
        sec_neg   = sec_diff[32];
        sec_pos   = !sec_diff[32] && (sec_diff != 33'sd0);
        nd_neg    = nsec_diff[31];
        nd_pos    = !nsec_diff[31] && (nsec_diff != 32'sd0);

        // Borrow across the second boundary folds one second into ns.
        if (sec_pos && nd_neg)
        begin
            sec_adj = NS_PER_SEC;
        end
        else if (sec_neg && nd_pos)
        begin
            sec_adj = -NS_PER_SEC;
        end
        else
        begin
            sec_adj = 33'sd0;
        end

        shift_full   = {nsec_diff[31], nsec_diff} + sec_adj;
        shift_zero   = (shift_full == 33'sd0);
        whole_sec_ok = (sec_diff == 33'sd0)
                    || (sec_pos && nd_neg && sec_diff == 33'sd1)
                    || (sec_neg && nd_pos && sec_diff == -33'sd1);
        fifo_full    = (fill_count_reg == FILL_W'(FIFO_DEPTH));
    end

    // ------------------------------------------------------------------
    // Read-modify-write of the state for the accepted word
    // ------------------------------------------------------------------
    always_comb
    begin
        exp_sec_next    = exp_sec_reg;
        exp_nsec_next   = exp_nsec_reg;
        sync_count_next = sync_count_reg;
        rd_ptr_next     = rd_ptr_reg;
        wr_ptr_next     = wr_ptr_reg;
        fill_count_next = fill_count_reg;
        s1_status_next  = ST_STORED;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        loss            = 1'b0;
        push_req        = 1'b0;
        wr_data.shift   = shift_full[SHIFT_W-1:0];
        wr_data.count   = sync_count_reg;
        wr_data.sec     = stamp_sec;
        wr_data.nsec    = stamp_nsec;

        if (item_accept)
        begin
            unique case (action_t'(action))
                ACT_PULSE:
                begin
                    exp_sec_next = xs;
                    if (!whole_sec_ok)
                    begin
                        // Loss is reported once until the next push resyncs.
                        if (sync_count_reg[COUNT_W-1])
                        begin
                            s1_status_next = ST_LOSS_REPORTED;
                        end
                        else
                        begin
                            loss     = 1'b1;
                            push_req = 1'b1;
                        end
                    end
                    else if (shift_zero && !sync_count_reg[COUNT_W-1])
                    begin
                        if (sync_count_reg != SYNC_MAX)
                        begin
                            sync_count_next = sync_count_reg + 32'sd1;
                        end
                        s1_status_next = ST_IN_SYNC;
                    end
                    else
                    begin
                        push_req = 1'b1;
                    end

                    if (loss)
                    begin
                        wr_data.count   = -32'sd1;
                        exp_sec_next    = stamp_sec;
                        exp_nsec_next   = {1'b0, stamp_nsec};
                        sync_count_next = -32'sd1;
                    end

                    if (push_req)
                    begin
                        if (fifo_full)
                        begin
                            s1_status_next = ST_FULL_DROP;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            sync_count_next = '0;
                            exp_sec_next    = stamp_sec;
                            exp_nsec_next   = {1'b0, stamp_nsec};
                            wr_ptr_next     = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ?
                                              '0 : wr_ptr_reg + PTR_W'(1);
                            fill_count_next = fill_count_reg + FILL_W'(1);
                            s1_status_next  = ST_STORED;
                        end
                    end
                end
                ACT_POP:
                begin
                    if (fill_count_reg == '0)
                    begin
                        s1_status_next = ST_EMPTY;
                    end
                    else
                    begin
                        mem_re          = 1'b1;
                        rd_ptr_next     = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ?
                                          '0 : rd_ptr_reg + PTR_W'(1);
                        fill_count_next = fill_count_reg - FILL_W'(1);
                        s1_status_next  = ST_POPPED;
                    end
                end
                ACT_CLEAR:
                begin
                    rd_ptr_next     = '0;
                    wr_ptr_next     = '0;
                    fill_count_next = '0;
                    sync_count_next = '0;
                    exp_sec_next    = -32'sd1;
                    exp_nsec_next   = -31'sd1;
                    s1_status_next  = ST_CLEARED;
                end
                ACT_RSVD:
                begin
                    s1_status_next = ST_BAD_ACTION;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Event memory: one write port, one registered read port. A push and a
    // pop never share a cycle, and a pop reads only committed entries.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            event_mem[wr_ptr_reg] <= wr_data;
        end
        if (mem_re)
        begin
            rd_data_reg <= event_mem[rd_ptr_reg];
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_sec_reg    <= '0;
            exp_nsec_reg   <= '0;
            sync_count_reg <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            fill_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            exp_sec_reg    <= exp_sec_next;
            exp_nsec_reg   <= exp_nsec_next;
            sync_count_reg <= sync_count_next;
            rd_ptr_reg     <= rd_ptr_next;
            wr_ptr_reg     <= wr_ptr_next;
            fill_count_reg <= fill_count_next;

            if (item_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s2_load)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s2_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline payload (no reset needed)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_status_reg <= s1_status_next;
            s1_fill_reg   <= fill_count_next;
            s1_pop_reg    <= mem_re;
        end
        if (s2_load)
        begin
            out_status_reg <= s1_status_reg;
            out_fill_reg   <= s1_fill_reg;
            out_shift_reg  <= s1_pop_reg ? rd_data_reg.shift : '0;
            out_count_reg  <= s1_pop_reg ? rd_data_reg.count : '0;
            out_sec_reg    <= s1_pop_reg ? rd_data_reg.sec   : '0;
            out_nsec_reg   <= s1_pop_reg ? rd_data_reg.nsec  : '0;
        end
    end

    assign result_valid   = out_valid_reg;
    assign status         = out_status_reg;
    assign shift_out      = out_shift_reg;
    assign sync_count_out = out_count_reg;
    assign event_sec      = out_sec_reg;
    assign event_nsec     = out_nsec_reg;
    assign fill_level     = out_fill_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_W'(FIFO_DEPTH))
        else $error("fill count above FIFO depth");

    a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
        item_accept && action == ACT_POP && fill_count_reg != '0
        |=> s1_valid_reg && s1_pop_reg && s1_status_reg == ST_POPPED)
        else $error("pop of a non-empty FIFO did not issue a read");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_POPPED
        |-> shift_out == '0 && sync_count_out == '0 && event_sec == '0
            && event_nsec == '0)
        else $error("event fields nonzero outside a pop");

    a_sync_neg: assert property (@(posedge clk) disable iff (!rst_n)
        sync_count_reg[COUNT_W-1] |-> sync_count_reg == -32'sd1)
        else $error("sync count negative but not the loss mark");

endmodule

@@ dv/pps_drift_monitor_fifo_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for pps_drift_monitor_fifo_unit: directed and random words,
// a scoreboard class that predicts every result word. Depends on pdm_pkg and the block.
module pps_drift_monitor_fifo_unit_tb;
    import pdm_pkg::*;

    localparam int  RANDOM_WORDS = 650;
    localparam int  PHASE_LEN    = 110;     // words per traffic phase (fill / hover / drain)
    localparam int  CYCLE_LIMIT  = 400000;  // far above the slowest correct run
    localparam int  TAIL_CYCLES  = 8;       // leave room for stray words

    // One result word, at the block's widths.
    typedef struct packed {
        logic [2:0]                status;
        logic signed [SHIFT_W-1:0] shift;
        logic signed [COUNT_W-1:0] count;
        logic signed [SEC_W-1:0]   sec;
        logic [NSEC_W-1:0]         nsec;
        logic [FILL_W-1:0]         fill;
    } drift_result_t;

    // Predicts the block word by word and holds the results still owed by it.
    class drift_scoreboard;
        logic signed [SEC_W-1:0]   exp_sec;
        logic signed [SHIFT_W-1:0] exp_nsec;     // goes to -1 on a clear
        logic signed [COUNT_W-1:0] sync_cnt;     // -1 after an unreported loss
        fifo_entry_t               event_fifo[$];
        drift_result_t             due_results[$];
        int                        errors;

        function new();
            exp_sec  = '0;
            exp_nsec = '0;
            sync_cnt = '0;
            errors   = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            errors++;
        endfunction

        // One pulse edge: drift against the expected time, then sync / loss / push.
        function status_t track_pulse(logic signed [SEC_W-1:0] s, logic [NSEC_W-1:0] n);
            longint      ts, tn, xs, xn, ds, dn, shift;
            bit          late;
            fifo_entry_t ent;
            ts = longint'(s);
            tn = longint'(n);
            exp_sec = exp_sec + 32'sd1;   // wraps at 32 bits
            xs = longint'(exp_sec);
            xn = longint'(exp_nsec);
            if (xs > ts)
            begin
                late = 1'b0;
                if (xn >= tn)
                begin
                    ds = xs - ts;
                    dn = xn - tn;
                end
                else
                begin
                    ds = xs - ts - 1;
                    dn = longint'(NS_PER_SEC) + xn - tn;
                end
            end
            else if (xs < ts)
            begin
                late = 1'b1;
                if (tn >= xn)
                begin
                    ds = ts - xs;
                    dn = tn - xn;
                end
                else
                begin
                    ds = ts - xs - 1;
                    dn = longint'(NS_PER_SEC) + tn - xn;
                end
            end
            else
            begin
                ds   = 0;
                late = (xn < tn);
                dn   = late ? (tn - xn) : (xn - tn);
            end
            shift = late ? -dn : dn;

            if (ds != 0)
            begin
                if (sync_cnt < 0)
                    return ST_LOSS_REPORTED;
                exp_sec  = ts[SEC_W-1:0];
                exp_nsec = tn[SHIFT_W-1:0];
                sync_cnt = -32'sd1;
            end
            else if (dn == 0 && sync_cnt >= 0)
            begin
                if (sync_cnt != SYNC_MAX)
                    sync_cnt = sync_cnt + 32'sd1;
                return ST_IN_SYNC;
            end

            // loss changes above stay even when the push is dropped
            if (event_fifo.size() >= FIFO_DEPTH)
                return ST_FULL_DROP;
            ent.shift = shift[SHIFT_W-1:0];
            ent.count = sync_cnt;
            ent.sec   = ts[SEC_W-1:0];
            ent.nsec  = tn[NSEC_W-1:0];
            event_fifo.push_back(ent);
            sync_cnt = '0;
            exp_sec  = ts[SEC_W-1:0];
            exp_nsec = tn[SHIFT_W-1:0];
            return ST_STORED;
        endfunction

        // Called at the edge that accepts an input word.
        function void note_word(action_t act, logic signed [SEC_W-1:0] s,
                                logic [NSEC_W-1:0] n);
            drift_result_t r;
            fifo_entry_t   e;
            r = '0;
            case (act)
                ACT_PULSE: r.status = track_pulse(s, n);
                ACT_POP:
                begin
                    if (event_fifo.size() == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        e = event_fifo.pop_front();
                        r.status = ST_POPPED;
                        r.shift  = e.shift;
                        r.count  = e.count;
                        r.sec    = e.sec;
                        r.nsec   = e.nsec;
                    end
                end
                ACT_CLEAR:
                begin
                    event_fifo.delete();
                    sync_cnt = '0;
                    exp_sec  = -32'sd1;
                    exp_nsec = -31'sd1;
                    r.status = ST_CLEARED;
                end
                default: r.status = ST_BAD_ACTION;
            endcase
            r.fill = FILL_W'(event_fifo.size());
            due_results.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report($sformatf("%s got %0h expected %0h", name, got, want));
        endfunction

        // Called at the edge that accepts a result word.
        function void check_result(drift_result_t got);
            drift_result_t want;
            if (due_results.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            want = due_results.pop_front();
            check_field("status",         64'(got.status), 64'(want.status));
            check_field("shift_out",      64'(got.shift),  64'(want.shift));
            check_field("sync_count_out", 64'(got.count),  64'(want.count));
            check_field("event_sec",      64'(got.sec),    64'(want.sec));
            check_field("event_nsec",     64'(got.nsec),   64'(want.nsec));
            check_field("fill_level",     64'(got.fill),   64'(want.fill));
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      item_valid;
    logic                      item_stall;
    logic [1:0]                action;
    logic signed [SEC_W-1:0]   stamp_sec;
    logic [NSEC_W-1:0]         stamp_nsec;
    logic                      result_valid;
    logic                      result_stall;
    logic [2:0]                status;
    logic signed [SHIFT_W-1:0] shift_out;
    logic signed [COUNT_W-1:0] sync_count_out;
    logic signed [SEC_W-1:0]   event_sec;
    logic [NSEC_W-1:0]         event_nsec;
    logic [FILL_W-1:0]         fill_level;

    drift_scoreboard sb = new();

    // Traffic shape, changed per phase by the stimulus process.
    int pop_pct   = 30;
    int exact_pct = 50;
    int clear_pct = 2;
    bit calm      = 1'b0;    // no idling on either side
    int cycle_count = 0;

    pps_drift_monitor_fifo_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .stamp_sec      (stamp_sec),
        .stamp_nsec     (stamp_nsec),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .status         (status),
        .shift_out      (shift_out),
        .sync_count_out (sync_count_out),
        .event_sec      (event_sec),
        .event_nsec     (event_nsec),
        .fill_level     (fill_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Idle length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one word from a rising edge, hold it until taken, then idle a while.
    // Stall is sampled at the falling edge, where every signal has settled.
    task automatic send_word(action_t act, logic signed [SEC_W-1:0] s, logic [NSEC_W-1:0] n);
        bit taken;
        int gap;
        item_valid <= 1'b1;
        action     <= act;
        stamp_sec  <= s;
        stamp_nsec <= n;
        do
        begin
            @(negedge clk);
            taken = !item_stall;
            @(posedge clk);
        end
        while (!taken);
        sb.note_word(act, s, n);
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random word shaped around the current expected time so that most pulses
    // land in sync or near it; the rest are second misses and raw noise.
    task automatic random_word(output action_t act, output logic signed [SEC_W-1:0] s,
                               output logic [NSEC_W-1:0] n);
        int                      r;
        int                      k;
        longint                  xn;
        longint                  tn;
        logic signed [SEC_W-1:0] xs;
        act = ACT_PULSE;
        s   = $urandom;
        n   = NSEC_W'($urandom_range(0, 999999999));
        r   = $urandom_range(0, 99);
        if (r < clear_pct)
            act = ACT_CLEAR;
        else if (r < clear_pct + pop_pct)
            act = ACT_POP;
        else if (r < clear_pct + pop_pct + 1)
            act = ACT_RSVD;
        else
        begin
            xs = sb.exp_sec + 32'sd1;
            xn = (sb.exp_nsec < 0) ? 0 : longint'(sb.exp_nsec);
            k  = $urandom_range(0, 99);
            if (k < exact_pct)
            begin
                s = xs;
                n = xn[NSEC_W-1:0];
            end
            else if (k < 88)
            begin
                // offset under one second, small most of the time
                if (k < 80)
                    tn = xn + longint'($urandom_range(0, 20000)) - 10000;
                else
                    tn = xn + longint'($urandom_range(0, 1999999998)) - 999999999;
                s = xs;
                if (tn < 0)
                begin
                    tn = tn + longint'(NS_PER_SEC);
                    s  = xs - 32'sd1;
                end
                else if (tn >= longint'(NS_PER_SEC))
                begin
                    tn = tn - longint'(NS_PER_SEC);
                    s  = xs + 32'sd1;
                end
                n = tn[NSEC_W-1:0];
            end
            else if (k < 96)
            begin
                // whole-second miss
                if ($urandom_range(0, 1) == 1)
                    s = xs + $urandom_range(1, 3);
                else
                    s = xs - $urandom_range(1, 3);
            end
            else if ($urandom_range(0, 3) == 0)
                n = NSEC_W'($urandom);    // random nanoseconds over all 30 bits, at times past one second
        end
    endtask

    // Result side: random stall, with calm stretches.
    initial
    begin : result_stall_drive
        int stall_left;
        int n;
        stall_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                result_stall <= 1'b1;
                stall_left = stall_left - 1;
            end
            else
            begin
                n = calm ? 0 : pick_gap();
                result_stall <= (n > 0);
                stall_left = (n > 0) ? n - 1 : 0;
            end
        end
    end

    // Result side: capture at the falling edge, check at the accepting edge.
    initial
    begin : result_monitor
        bit            take;
        drift_result_t got;
        forever
        begin
            @(negedge clk);
            take = (result_valid === 1'b1) && (result_stall === 1'b0) && rst_n;
            got  = '{status, shift_out, sync_count_out, event_sec, event_nsec, fill_level};
            @(posedge clk);
            if (take)
                sb.check_result(got);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        action_t                 act;
        logic signed [SEC_W-1:0] s;
        logic [NSEC_W-1:0]       n;
        int                      i;
        int                      phase;

        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        action     <= ACT_PULSE;
        stamp_sec  <= '0;
        stamp_nsec <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed words ---
        send_word(ACT_POP,   0, 0);                          // pop while empty
        send_word(ACT_PULSE, 1, 0);                          // in sync from reset
        send_word(ACT_PULSE, 2, 0);
        send_word(ACT_PULSE, 3, 100);                        // late 100 ns, count 2
        send_word(ACT_PULSE, 3, 999999950);                  // early across the second
        send_word(ACT_PULSE, 10, 5);                         // whole-second miss
        send_word(ACT_PULSE, 32'sh7FFF_FFFF, 999999999);     // miss to top second
        send_word(ACT_PULSE, 32'sh8000_0000, 999999999);     // second wraps, in sync
        send_word(ACT_PULSE, 32'sh8000_0001, 30'h3FFF_FFFF); // nanoseconds past range
        send_word(ACT_PULSE, 32'sh8000_0002, 0);             // large early shift
        send_word(ACT_RSVD,  32'sh7FFF_FFFF, 30'h3FFF_FFFF); // reserved action
        repeat (4) send_word(ACT_POP, 0, 0);
        send_word(ACT_CLEAR, 0, 0);
        send_word(ACT_PULSE, 0, 0);                          // after clear: late by 1 ns
        send_word(ACT_PULSE, 1, 0);
        send_word(ACT_PULSE, 2, 999999999);                  // most negative shift
        send_word(ACT_PULSE, 3, 0);                          // most positive shift
        repeat (4) send_word(ACT_POP, 0, 0);                 // last one finds it empty

        // --- random words in phases: fill to overflow, hover near full, drain ---
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % PHASE_LEN == 0)
            begin
                phase = (i / PHASE_LEN) % 3;
                pop_pct   = (phase == 0) ? 3 : (phase == 1) ? 30 : 65;
                exact_pct = (phase == 0) ? 25 : 50;
                clear_pct = (phase == 0) ? 0 : 2;
                calm      = ((i / PHASE_LEN) % 4 == 3);
            end
            random_word(act, s, n);
            send_word(act, s, n);
        end
        item_valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/pdm_pkg.sv
design/pps_drift_monitor_fifo_unit.sv
dv/pps_drift_monitor_fifo_unit_tb.sv
